// File: rtl/tmb_pkg.sv
// Shared types, codes and sizes for the soft timer bank.
// Used by the interfaces and by every module of the block.
`timescale 1ns / 1ps

package tmb_pkg;

  localparam int NUM_TIMERS = 8;
  localparam int SLOT_FIELD_LIMIT = 8;
  localparam int USABLE_SLOTS = (NUM_TIMERS < SLOT_FIELD_LIMIT) ? NUM_TIMERS : SLOT_FIELD_LIMIT;
  localparam int IDX_W = (USABLE_SLOTS > 1) ? $clog2(USABLE_SLOTS) : 1;
  localparam int CNT_W = $clog2(USABLE_SLOTS + 1);

  localparam int FUNC_W = 3;
  localparam int SLOT_W = 3;
  localparam int KIND_W = 2;
  localparam int WORD_W = 32;
  localparam int RS_W   = 2;

  localparam logic [FUNC_W-1:0] FN_CREATE  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_START   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_STOP    = 3'd2;
  localparam logic [FUNC_W-1:0] FN_DELETE  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_PROCESS = 3'd4;

  localparam logic [KIND_W-1:0] KIND_DONE    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FAIL    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd2;

  localparam logic [RS_W-1:0] RS_STOPPED = 2'd0;
  localparam logic [RS_W-1:0] RS_RUNNING = 2'd1;
  localparam logic [RS_W-1:0] RS_TIMEOUT = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot_out;
    logic [WORD_W-1:0] tag_out;
    logic              last;
  } res_t;

  typedef struct packed {
    logic push;
    res_t res;
  } push_t;

endpackage

// File: rtl/tmb_if.sv
// Valid/ready channel interfaces for commands and results of the timer bank.
// Depends on tmb_pkg for field widths.
`timescale 1ns / 1ps

interface tmb_in_if;
  logic                      valid;
  logic                      ready;
  logic [tmb_pkg::FUNC_W-1:0] func;
  logic [tmb_pkg::SLOT_W-1:0] slot;
  logic                      mode;
  logic [tmb_pkg::WORD_W-1:0] period;
  logic [tmb_pkg::WORD_W-1:0] tag;
  logic [tmb_pkg::WORD_W-1:0] now;

  modport source (output valid, func, slot, mode, period, tag, now, input ready);
  modport sink (input valid, func, slot, mode, period, tag, now, output ready);
endinterface

interface tmb_out_if;
  logic                      valid;
  logic                      ready;
  logic [tmb_pkg::KIND_W-1:0] kind;
  logic [tmb_pkg::SLOT_W-1:0] slot_out;
  logic [tmb_pkg::WORD_W-1:0] tag_out;
  logic                      last;

  modport source (output valid, kind, slot_out, tag_out, last, input ready);
  modport sink (input valid, kind, slot_out, tag_out, last, output ready);
endinterface

// File: rtl/multi_channel_soft_timer_bank.sv
// Top level of the soft timer bank: command sequencer plus result register.
// Depends on tmb_pkg, tmb_if, tmb_ctrl and tmb_out_reg.
`timescale 1ns / 1ps

// Each command is taken in one transfer and then executed while the command
// channel holds ready low. Create scans for the lowest free slot, one slot per
// cycle while the result register can take a result. A process pass visits
// every slot once through the shared adder and comparator. The sequencer
// waits in any cycle in which the result register is still full and not
// taken. Expiry results leave in slot order, the last one marked; a pass with
// no expiry gives one done result.

module multi_channel_soft_timer_bank (
  input  logic      clk,
  input  logic      rst,
  tmb_in_if.sink    in_ch,
  tmb_out_if.source out_ch
);
  import tmb_pkg::*;

  push_t push;
  logic  out_free;

  tmb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_free (out_free),
    .push_o   (push)
  );

  tmb_out_reg u_out_reg (
    .clk    (clk),
    .rst    (rst),
    .push_i (push),
    .free   (out_free),
    .out_ch (out_ch)
  );

endmodule

// File: rtl/tmb_alu.sv
// Shared arithmetic unit: one 32-bit adder and one unsigned compare.
// Depends on tmb_pkg.
`timescale 1ns / 1ps

module tmb_alu (
  input  logic [tmb_pkg::WORD_W-1:0] add_a,
  input  logic [tmb_pkg::WORD_W-1:0] add_b,
  input  logic [tmb_pkg::WORD_W-1:0] cmp_a,
  input  logic [tmb_pkg::WORD_W-1:0] cmp_b,
  output logic [tmb_pkg::WORD_W-1:0] sum,
  output logic                       le
);
  import tmb_pkg::*;

  assign sum = add_a + add_b;
  assign le  = (cmp_a <= cmp_b);

endmodule

// File: rtl/tmb_out_reg.sv
// Output register between the sequencer and the result channel.
// Depends on tmb_pkg and tmb_out_if.
`timescale 1ns / 1ps

module tmb_out_reg (
  input  logic            clk,
  input  logic            rst,
  input  tmb_pkg::push_t  push_i,
  output logic            free,
  tmb_out_if.source       out_ch
);
  import tmb_pkg::*;

  logic valid;
  res_t data;

  assign free = !valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (push_i.push) begin
      valid <= 1'b1;
    end else if (out_ch.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i.push) begin
      data <= push_i.res;
    end
  end

  assign out_ch.valid    = valid;
  assign out_ch.kind     = data.kind;
  assign out_ch.slot_out = data.slot_out;
  assign out_ch.tag_out  = data.tag_out;
  assign out_ch.last     = data.last;

  a_push_sets_valid: assert property (@(posedge clk) disable iff (rst)
    push_i.push |=> valid) else $error("result register lost a transfer");

endmodule

// File: rtl/tmb_ctrl.sv
// Sequencer and slot storage: walks the slots one per cycle through tmb_alu
// while the result register is free. Depends on tmb_pkg, tmb_in_if, tmb_alu.
`timescale 1ns / 1ps

module tmb_ctrl (
  input  logic           clk,
  input  logic           rst,
  tmb_in_if.sink         in_ch,
  input  logic           out_free,
  output tmb_pkg::push_t push_o
);
  import tmb_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic              state;
  logic [CNT_W-1:0]  idx;
  logic [FUNC_W-1:0] c_func;
  logic [SLOT_W-1:0] c_slot;
  logic              c_mode;
  logic [WORD_W-1:0] c_period;
  logic [WORD_W-1:0] c_tag;
  logic [WORD_W-1:0] c_now;
  logic              have_pend;
  logic [SLOT_W-1:0] pend_slot;
  logic [WORD_W-1:0] pend_tag;

  logic              in_use   [USABLE_SLOTS];
  logic [RS_W-1:0]   rs       [USABLE_SLOTS];
  logic              mode_m   [USABLE_SLOTS];
  logic [WORD_W-1:0] period_m [USABLE_SLOTS];
  logic [WORD_W-1:0] match_m  [USABLE_SLOTS];
  logic [WORD_W-1:0] tag_m    [USABLE_SLOTS];

  logic [IDX_W-1:0]  ix;
  logic [IDX_W-1:0]  cix;
  logic              at_end;
  logic              cmd_ok;
  logic              step;
  logic              accept;
  logic [WORD_W-1:0] add_b;
  logic [WORD_W-1:0] sum;
  logic              le;

  logic done, adv, wr_create, expire, reload, to_stop, set_run, set_stop, set_free;

  assign ix     = idx[IDX_W-1:0];
  assign cix    = c_slot[IDX_W-1:0];
  assign at_end = (idx == CNT_W'(USABLE_SLOTS));
  assign cmd_ok = ({1'b0, c_slot} < (SLOT_W + 1)'(USABLE_SLOTS)) && in_use[cix];
  assign step   = (state == S_EXEC) && out_free;
  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == S_IDLE);

  assign add_b = (c_func == FN_CREATE) ? c_period : period_m[ix];

  tmb_alu u_alu (
    .add_a (c_now),
    .add_b (add_b),
    .cmp_a (match_m[ix]),
    .cmp_b (c_now),
    .sum   (sum),
    .le    (le)
  );

  always_comb begin
    push_o    = '0;
    done      = 1'b0;
    adv       = 1'b0;
    wr_create = 1'b0;
    expire    = 1'b0;
    reload    = 1'b0;
    to_stop   = 1'b0;
    set_run   = 1'b0;
    set_stop  = 1'b0;
    set_free  = 1'b0;
    if (step) begin
      push_o.res.last = 1'b1;
      unique case (c_func)
        FN_CREATE: begin
          if (at_end) begin
            push_o.push     = 1'b1;
            push_o.res.kind = KIND_FAIL;
            done            = 1'b1;
          end else if (!in_use[ix]) begin
            push_o.push         = 1'b1;
            push_o.res.kind     = KIND_DONE;
            push_o.res.slot_out = SLOT_W'(ix);
            wr_create           = 1'b1;
            done                = 1'b1;
          end else begin
            adv = 1'b1;
          end
        end
        FN_START, FN_STOP, FN_DELETE: begin
          push_o.push         = 1'b1;
          push_o.res.kind     = cmd_ok ? KIND_DONE : KIND_FAIL;
          push_o.res.slot_out = c_slot;
          done                = 1'b1;
          set_run             = cmd_ok && (c_func == FN_START);
          set_stop            = cmd_ok && (c_func != FN_START);
          set_free            = cmd_ok && (c_func == FN_DELETE);
        end
        FN_PROCESS: begin
          if (at_end) begin
            push_o.push = 1'b1;
            done        = 1'b1;
            if (have_pend) begin
              push_o.res.kind     = KIND_EXPIRED;
              push_o.res.slot_out = pend_slot;
              push_o.res.tag_out  = pend_tag;
            end else begin
              push_o.res.kind = KIND_DONE;
            end
          end else begin
            adv = 1'b1;
            if (in_use[ix] && rs[ix] == RS_RUNNING && le) begin
              expire = 1'b1;
              if (have_pend) begin
                push_o.push         = 1'b1;
                push_o.res.kind     = KIND_EXPIRED;
                push_o.res.slot_out = pend_slot;
                push_o.res.tag_out  = pend_tag;
                push_o.res.last     = 1'b0;
              end
            end else if (in_use[ix] && rs[ix] == RS_TIMEOUT) begin
              to_stop = !mode_m[ix];
              reload  = mode_m[ix];
            end
          end
        end
        default: begin
          push_o.push         = 1'b1;
          push_o.res.kind     = KIND_FAIL;
          push_o.res.slot_out = c_slot;
          done                = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      have_pend <= 1'b0;
    end else if (accept) begin
      state     <= S_EXEC;
      idx       <= '0;
      have_pend <= 1'b0;
    end else begin
      if (done) begin
        state <= S_IDLE;
      end
      if (adv) begin
        idx <= idx + CNT_W'(1);
      end
      if (expire) begin
        have_pend <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      c_func   <= in_ch.func;
      c_slot   <= in_ch.slot;
      c_mode   <= in_ch.mode;
      c_period <= in_ch.period;
      c_tag    <= in_ch.tag;
      c_now    <= in_ch.now;
    end
    if (expire) begin
      pend_slot <= SLOT_W'(ix);
      pend_tag  <= tag_m[ix];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < USABLE_SLOTS; i++) begin
        in_use[i] <= 1'b0;
        rs[i]     <= RS_STOPPED;
      end
    end else begin
      if (wr_create) begin
        in_use[ix] <= 1'b1;
        rs[ix]     <= RS_STOPPED;
      end
      if (expire) begin
        rs[ix] <= RS_TIMEOUT;
      end
      if (to_stop) begin
        rs[ix] <= RS_STOPPED;
      end
      if (reload) begin
        rs[ix] <= RS_RUNNING;
      end
      if (set_run) begin
        rs[cix] <= RS_RUNNING;
      end
      if (set_stop) begin
        rs[cix] <= RS_STOPPED;
      end
      if (set_free) begin
        in_use[cix] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_create) begin
      mode_m[ix]   <= c_mode;
      period_m[ix] <= c_period;
      match_m[ix]  <= sum;
      tag_m[ix]    <= c_tag;
    end
    if (reload) begin
      match_m[ix] <= sum;
    end
  end

  a_push_when_free: assert property (@(posedge clk) disable iff (rst)
    push_o.push |-> out_free) else $error("result pushed into a full register");

  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    (push_o.push && push_o.res.last) |=> state == S_IDLE)
    else $error("sequencer kept working after the final result");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_EXEC |-> idx <= CNT_W'(USABLE_SLOTS)) else $error("slot scan overran");

endmodule

// File: tb/tmb_result_checker.sv
// Checker for the soft timer bank: watches both channels, predicts the results of
// every accepted command and compares them in order. Depends on tmb_pkg and tmb_if.
`timescale 1ns / 1ps

module tmb_result_checker
  import tmb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  tmb_in_if    cmd,
  tmb_out_if   rsp,
  output int   fail_count,
  output int   pending
);

  localparam int SLOT_COUNT = 1 << SLOT_W;

  logic [SLOT_COUNT-1:0] timer_in_use;
  logic [RS_W-1:0]       timer_state  [SLOT_COUNT];
  logic                  timer_mode   [SLOT_COUNT];
  logic [WORD_W-1:0]     timer_period [SLOT_COUNT];
  logic [WORD_W-1:0]     timer_match  [SLOT_COUNT];
  logic [WORD_W-1:0]     timer_tag    [SLOT_COUNT];

  res_t expected_results[$];

  function automatic res_t make_res(logic [KIND_W-1:0] kind, logic [SLOT_W-1:0] slot,
                                    logic [WORD_W-1:0] tag, logic last);
    res_t r;
    r.kind = kind;
    r.slot_out = slot;
    r.tag_out = tag;
    r.last = last;
    return r;
  endfunction

  task automatic apply_command(logic [FUNC_W-1:0] func, logic [SLOT_W-1:0] slot, logic mode,
                               logic [WORD_W-1:0] period, logic [WORD_W-1:0] tag,
                               logic [WORD_W-1:0] now);
    bit                    found;
    bit                    usable;
    int                    last_hit;
    logic [SLOT_COUNT-1:0] fired;
    usable = (int'(slot) < USABLE_SLOTS) && timer_in_use[slot];
    case (func)
      FN_CREATE: begin
        found = 1'b0;
        for (int i = 0; i < USABLE_SLOTS; i++) begin
          if (!found && !timer_in_use[i]) begin
            found = 1'b1;
            timer_in_use[i] = 1'b1;
            timer_state[i] = RS_STOPPED;
            timer_mode[i] = mode;
            timer_period[i] = period;
            timer_match[i] = now + period;
            timer_tag[i] = tag;
            expected_results.push_back(make_res(KIND_DONE, SLOT_W'(i), '0, 1'b1));
          end
        end
        if (!found) expected_results.push_back(make_res(KIND_FAIL, '0, '0, 1'b1));
      end
      FN_START, FN_STOP, FN_DELETE: begin
        if (!usable) begin
          expected_results.push_back(make_res(KIND_FAIL, slot, '0, 1'b1));
        end else begin
          if (func == FN_START) begin
            timer_state[slot] = RS_RUNNING;
          end else begin
            timer_state[slot] = RS_STOPPED;
            if (func == FN_DELETE) timer_in_use[slot] = 1'b0;
          end
          expected_results.push_back(make_res(KIND_DONE, slot, '0, 1'b1));
        end
      end
      FN_PROCESS: begin
        fired = '0;
        last_hit = -1;
        for (int i = 0; i < USABLE_SLOTS; i++) begin
          if (timer_in_use[i]) begin
            if (timer_state[i] == RS_RUNNING) begin
              if (timer_match[i] <= now) begin
                timer_state[i] = RS_TIMEOUT;
                fired[i] = 1'b1;
                last_hit = i;
              end
            end else if (timer_state[i] == RS_TIMEOUT) begin
              if (!timer_mode[i]) begin
                timer_state[i] = RS_STOPPED;
              end else begin
                timer_match[i] = now + timer_period[i];
                timer_state[i] = RS_RUNNING;
              end
            end
          end
        end
        if (last_hit < 0) begin
          expected_results.push_back(make_res(KIND_DONE, '0, '0, 1'b1));
        end else begin
          for (int i = 0; i <= last_hit; i++) begin
            if (fired[i]) begin
              expected_results.push_back(make_res(KIND_EXPIRED, SLOT_W'(i), timer_tag[i],
                                                  i == last_hit));
            end
          end
        end
      end
      default: begin
        expected_results.push_back(make_res(KIND_FAIL, slot, '0, 1'b1));
      end
    endcase
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      timer_in_use = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        timer_state[i] = RS_STOPPED;
        timer_mode[i] = 1'b0;
        timer_period[i] = '0;
        timer_match[i] = '0;
        timer_tag[i] = '0;
      end
      expected_results.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (cmd.valid && cmd.ready) begin
        apply_command(cmd.func, cmd.slot, cmd.mode, cmd.period, cmd.tag, cmd.now);
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got kind %0d slot %0d tag %h last %0b",
                   $time, rsp.kind, rsp.slot_out, rsp.tag_out, rsp.last);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (rsp.kind !== want.kind || rsp.slot_out !== want.slot_out ||
              rsp.tag_out !== want.tag_out || rsp.last !== want.last) begin
            $display("%0t: result mismatch, expected kind %0d slot %0d tag %h last %0b",
                     $time, want.kind, want.slot_out, want.tag_out, want.last);
            $display("%0t:                  got kind %0d slot %0d tag %h last %0b",
                     $time, rsp.kind, rsp.slot_out, rsp.tag_out, rsp.last);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= expected_results.size();
    end
  end

endmodule

// File: tb/tb_top.sv
// Testbench top for the soft timer bank: clock, reset, command stimulus, result
// back-pressure and verdict. Depends on tmb_pkg, tmb_if and tmb_result_checker.
`timescale 1ns / 1ps

module tb_top;
  import tmb_pkg::*;

  localparam logic [FUNC_W-1:0] FN_UNUSED_FIRST = 3'd5;
  localparam logic [FUNC_W-1:0] FN_UNUSED_LAST  = 3'd7;
  localparam int SLOT_MAX       = (1 << SLOT_W) - 1;
  localparam int HOLD_CYCLES    = 120;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 24;
  localparam int PHASE_ITEMS    = 38;

  logic clk = 1'b0;
  logic rst;
  logic hold_start;
  int   idle_pct;
  int   stall_pct;
  int   quiet_cycles;
  int   fail_count;
  int   pending;
  logic [WORD_W-1:0] tick;

  tmb_in_if  cmd_ch ();
  tmb_out_if res_ch ();

  multi_channel_soft_timer_bank i_dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (cmd_ch),
    .out_ch(res_ch)
  );

  tmb_result_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .rsp       (res_ch),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // result side: random stalls, plus one long hold on request
  initial begin
    int hold_left;
    hold_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        res_ch.ready <= 1'b0;
      end else if (hold_start) begin
        hold_left = HOLD_CYCLES;
        res_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_cmd(logic [FUNC_W-1:0] func, logic [SLOT_W-1:0] slot, logic mode,
                          logic [WORD_W-1:0] period, logic [WORD_W-1:0] tag,
                          logic [WORD_W-1:0] now);
    while ($urandom_range(99) < idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.func <= func;
    cmd_ch.slot <= slot;
    cmd_ch.mode <= mode;
    cmd_ch.period <= period;
    cmd_ch.tag <= tag;
    cmd_ch.now <= now;
    do @(posedge clk); while (!cmd_ch.ready);
  endtask

  task automatic send_random();
    int                pick;
    logic [FUNC_W-1:0] func;
    logic [WORD_W-1:0] period;
    pick = $urandom_range(99);
    if (pick < 16) func = FN_CREATE;
    else if (pick < 42) func = FN_START;
    else if (pick < 50) func = FN_STOP;
    else if (pick < 57) func = FN_DELETE;
    else if (pick < 95) func = FN_PROCESS;
    else func = FUNC_W'($urandom_range(FN_UNUSED_LAST, FN_UNUSED_FIRST));
    if ($urandom_range(99) < 3) tick = $urandom();
    else tick = tick + $urandom_range(12);
    if ($urandom_range(99) < 10) period = $urandom();
    else period = $urandom_range(30);
    send_cmd(func, SLOT_W'($urandom_range(SLOT_MAX)), 1'($urandom_range(1)), period,
             $urandom(), tick);
  endtask

  initial begin
    rst <= 1'b1;
    hold_start <= 1'b0;
    cmd_ch.valid <= 1'b0;
    cmd_ch.func <= FN_PROCESS;
    cmd_ch.slot <= '0;
    cmd_ch.mode <= 1'b0;
    cmd_ch.period <= '0;
    cmd_ch.tag <= '0;
    cmd_ch.now <= '0;
    stall_pct <= 0;
    idle_pct = 0;
    tick = 32'd300;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // empty bank, commands on unused slots, unknown functions
    send_cmd(FN_PROCESS, 3'd0, 1'b0, '0, '0, '0);
    send_cmd(FN_START, 3'd0, 1'b0, '0, '0, 32'd10);
    send_cmd(FN_STOP, SLOT_W'(SLOT_MAX), 1'b1, '1, '1, 32'd10);
    send_cmd(FN_DELETE, 3'd5, 1'b0, '0, '0, 32'd10);
    for (int f = FN_UNUSED_FIRST; f <= FN_UNUSED_LAST; f++) begin
      send_cmd(FUNC_W'(f), SLOT_W'(f), 1'b1, '1, '1, '1);
    end

    // fill the bank, with period and tag extremes and a wrapped match
    send_cmd(FN_CREATE, '0, 1'b0, '0, '1, 32'd100);
    send_cmd(FN_CREATE, '0, 1'b1, 32'd5, '0, 32'd100);
    send_cmd(FN_CREATE, '0, 1'b0, '1, 32'hA5A5_A5A5, 32'd1);
    send_cmd(FN_CREATE, '0, 1'b1, '0, 32'd1, '1);
    for (int i = 4; i < USABLE_SLOTS; i++) begin
      send_cmd(FN_CREATE, '0, i[0], 32'd50, 32'h5A5A_0000 + i, 32'd100);
    end
    send_cmd(FN_CREATE, '0, 1'b1, 32'd7, 32'd7, 32'd100);

    // expire, stop one-shots, restart from timeout, delete in timeout
    for (int i = 0; i < 4; i++) send_cmd(FN_START, SLOT_W'(i), 1'b0, '0, '0, 32'd100);
    send_cmd(FN_PROCESS, '0, 1'b0, '0, '0, 32'd100);
    send_cmd(FN_PROCESS, '0, 1'b0, '0, '0, '1);
    send_cmd(FN_START, 3'd1, 1'b0, '0, '0, 32'd150);
    send_cmd(FN_DELETE, 3'd3, 1'b0, '0, '0, 32'd150);
    send_cmd(FN_PROCESS, '0, 1'b0, '0, '0, 32'd200);
    send_cmd(FN_DELETE, 3'd3, 1'b0, '0, '0, 32'd200);
    send_cmd(FN_CREATE, '0, 1'b1, 32'd3, 32'hDEAD_0003, 32'd200);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          idle_pct = 68;
          stall_pct <= 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct <= 68;
        end
        default: begin
          idle_pct = 7;
          stall_pct <= 7;
        end
      endcase
      if (ph == 0) begin
        // hold results back while commands keep coming
        cmd_ch.valid <= 1'b0;
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
      end
      for (int k = 0; k < PHASE_ITEMS; k++) send_random();
    end
    cmd_ch.valid <= 1'b0;

    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
